// ===== rtl/core/upwn_pkg.sv =====
// Shared types and constants for the UTF-8 punctuation width normalizer.
// No dependencies; imported by upwn_step and the top level.
package upwn_pkg;

    localparam int unsigned MAX_RESULTS = 4;
    localparam int unsigned CNT_W       = 3;

    localparam logic [20:0] CP_BAD   = 21'h00fffd;
    localparam logic [20:0] CJK_LO   = 21'h004e00;
    localparam logic [20:0] CJK_HI   = 21'h009fff;

    localparam logic [7:0] LEAD3_TAG = 8'he0;
    localparam logic [7:0] CONT_TAG  = 8'h80;

    // Punctuation pairs, same order in both tables
    localparam logic [7:0] ASCII_MARKS [8] = '{
        8'h2c, 8'h2e, 8'h21, 8'h3f, 8'h3b, 8'h3a, 8'h28, 8'h29
    };
    localparam logic [15:0] WIDE_MARKS [8] = '{
        16'hff0c, 16'h3002, 16'hff01, 16'hff1f,
        16'hff1b, 16'hff1a, 16'hff08, 16'hff09
    };

    // One finished part, ready for the output buffer
    typedef struct packed {
        logic [MAX_RESULTS-1:0][7:0] data;
        logic [CNT_W-1:0]            count;
        logic                        text_end;
    } upwn_part_t;

    function automatic logic is_cjk(input logic [20:0] cp);
        return (cp >= CJK_LO) && (cp <= CJK_HI);
    endfunction

    function automatic logic is_wordish(input logic [20:0] cp);
        return (cp >= 21'h30 && cp <= 21'h39) || (cp >= 21'h41 && cp <= 21'h5a) ||
               (cp >= 21'h61 && cp <= 21'h7a) || cp == 21'h27 || cp == 21'h22;
    endfunction

    function automatic logic is_space(input logic [20:0] cp);
        return cp == 21'h20 || cp == 21'h09 || cp == 21'h0d || cp == 21'h0a;
    endfunction

endpackage

// ===== rtl/core/upwn_step.sv =====
// Decoder state and per-byte step: groups bytes into parts and applies
// the width rewrite. Depends on upwn_pkg.
module upwn_step (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          in_byte,
    input  logic                text_end,
    output upwn_pkg::upwn_part_t part
);
    import upwn_pkg::*;

    logic [3:0][7:0] held_reg;
    logic [1:0]      held_count_reg, held_count_next;
    logic [1:0]      expected_reg, expected_next;
    logic [20:0]     partial_reg, partial_next;
    logic [20:0]     prior_reg, prior_next;

    logic        done, bad, hold_wr;
    logic [20:0] cp;
    logic        ascii_hit, wide_hit;
    logic [7:0]  ascii_sel;
    logic [15:0] wide_sel;
    logic        prior_cjk, prior_word;

    // Byte classification and next decoder state
    always_comb
    begin
        done            = 1'b0;
        bad             = 1'b0;
        hold_wr         = 1'b0;
        cp              = {13'd0, in_byte};
        expected_next   = expected_reg;
        partial_next    = partial_reg;
        held_count_next = held_count_reg;
        if (expected_reg == 2'd0)
        begin
            if (!in_byte[7])
            begin
                done = 1'b1;
            end
            else if (in_byte[7:5] == 3'b110)
            begin
                expected_next = 2'd1;
                partial_next  = {16'd0, in_byte[4:0]};
                hold_wr       = 1'b1;
            end
            else if (in_byte[7:4] == 4'b1110)
            begin
                expected_next = 2'd2;
                partial_next  = {17'd0, in_byte[3:0]};
                hold_wr       = 1'b1;
            end
            else if (in_byte[7:3] == 5'b11110)
            begin
                expected_next = 2'd3;
                partial_next  = {18'd0, in_byte[2:0]};
                hold_wr       = 1'b1;
            end
            else
            begin
                done = 1'b1;
                bad  = 1'b1;
            end
        end
        else if (in_byte[7:6] != 2'b10)
        begin
            done = 1'b1;
            bad  = 1'b1;
        end
        else
        begin
            partial_next  = {partial_reg[14:0], in_byte[5:0]};
            expected_next = expected_reg - 2'd1;
            if (expected_reg == 2'd1)
            begin
                done = 1'b1;
                cp   = partial_next;
            end
            else
            begin
                hold_wr = 1'b1;
            end
        end
        // Text end flushes whatever is unfinished as a bad part
        if (!done && text_end)
        begin
            done    = 1'b1;
            bad     = 1'b1;
            hold_wr = 1'b0;
        end
        if (hold_wr)
        begin
            held_count_next = held_count_reg + 2'd1;
        end
        if (done)
        begin
            held_count_next = 2'd0;
            expected_next   = 2'd0;
            partial_next    = '0;
        end
        if (bad)
        begin
            cp = CP_BAD;
        end
    end

    // Mark table lookups
    always_comb
    begin
        ascii_hit = 1'b0;
        wide_hit  = 1'b0;
        ascii_sel = 8'h00;
        wide_sel  = 16'h0000;
        for (int k = 0; k < 8; k++)
        begin
            if (!ascii_hit && cp == {13'd0, ASCII_MARKS[k]})
            begin
                ascii_hit = 1'b1;
                wide_sel  = WIDE_MARKS[k];
            end
            if (!wide_hit && cp == {5'd0, WIDE_MARKS[k]})
            begin
                wide_hit  = 1'b1;
                ascii_sel = ASCII_MARKS[k];
            end
        end
    end

    assign prior_cjk  = is_cjk(prior_reg);
    assign prior_word = is_wordish(prior_reg);

    // Build the emitted bytes
    always_comb
    begin
        part          = '0;
        part.text_end = text_end;
        prior_next    = prior_reg;
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            part.data[i] = (i < int'(held_count_reg)) ? held_reg[i] : in_byte;
        end
        if (done)
        begin
            part.count = {1'b0, held_count_reg} + 3'd1;
            if (!bad && held_count_reg == 2'd0 && prior_cjk && ascii_hit)
            begin
                part.data[0] = LEAD3_TAG | {4'd0, wide_sel[15:12]};
                part.data[1] = CONT_TAG | {2'd0, wide_sel[11:6]};
                part.data[2] = CONT_TAG | {2'd0, wide_sel[5:0]};
                part.count   = 3'd3;
            end
            else if (!bad && held_count_reg == 2'd2 && !prior_cjk && prior_word && wide_hit)
            begin
                part.data[0] = ascii_sel;
                part.count   = 3'd1;
            end
            if (!is_space(cp))
            begin
                prior_next = cp;
            end
            if (text_end)
            begin
                prior_next = '0;
            end
        end
    end

    // Held bytes carry no reset; only entries of the current part are read
    always_ff @(posedge clk)
    begin
        if (accept && hold_wr)
        begin
            held_reg[held_count_reg] <= in_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count_reg <= '0;
            expected_reg   <= '0;
            partial_reg    <= '0;
            prior_reg      <= '0;
        end
        else if (accept)
        begin
            held_count_reg <= held_count_next;
            expected_reg   <= expected_next;
            partial_reg    <= partial_next;
            prior_reg      <= prior_next;
        end
    end

`ifndef SYNTHESIS
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        expected_reg == 2'd0 |-> held_count_reg == 2'd0)
        else $error("held bytes with no sequence in progress");

    a_seq_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        expected_reg != 2'd0 |->
            held_count_reg != 2'd0 && ({1'b0, held_count_reg} + {1'b0, expected_reg}) <= 3'd4)
        else $error("sequence length out of range");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && text_end |=> expected_reg == 2'd0 && prior_reg == '0)
        else $error("text end did not clear history");
`endif

endmodule

// ===== rtl/core/utf8_punctuation_width_normalizer_core.sv =====
// Top level of the UTF-8 punctuation width normalizer: input handshake and
// output byte buffer. Depends on upwn_pkg and upwn_step.
//
// Usage:
//   s_* carries one raw UTF-8 byte per request (tlast marks the end of the
//   text). m_* carries normalized bytes; tlast marks the final byte emitted
//   for one input request, tuser the final byte of the whole text.
//   Each accepted byte is decoded in the cycle it is taken; the bytes it
//   releases (0 to 4) sit in a small output buffer and leave one per cycle
//   while the receiver is ready, so the first result byte appears in the
//   cycle after the input request is taken. Throughput: one input byte per
//   cycle while each request releases at most one byte and the receiver is
//   ready; a request releasing more bytes holds the input while the buffer
//   drains. A new byte is taken in the same cycle the last buffered byte leaves.
//   Reset clears the decoder state, the history and the buffer. When the
//   receiver stalls, the buffer holds and s_tready stays low until the last
//   buffered byte can leave.
module utf8_punctuation_width_normalizer_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // text_end
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast,   // run_last
    output logic       m_tuser    // [0] stream_done
);
    import upwn_pkg::*;

    logic                        s_fire, m_fire;
    upwn_part_t                  part;
    logic [MAX_RESULTS-1:0][7:0] buf_reg, buf_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic                        end_reg, end_next;

    assign s_fire = s_tvalid && s_tready;
    assign m_fire = m_tvalid && m_tready;

    upwn_step u_step (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (s_fire),
        .in_byte  (s_tdata),
        .text_end (s_tlast),
        .part     (part)
    );

    // Take a new request when the buffer is empty or its last byte leaves now
    assign s_tready = (cnt_reg == '0) || (cnt_reg == CNT_W'(1) && m_tready);

    assign m_tvalid = (cnt_reg != '0);
    assign m_tdata  = buf_reg[0];
    assign m_tlast  = (cnt_reg == CNT_W'(1));
    assign m_tuser  = (cnt_reg == CNT_W'(1)) && end_reg;

    // Output buffer: load a finished part or shift out one byte
    always_comb
    begin
        buf_next = buf_reg;
        cnt_next = cnt_reg;
        end_next = end_reg;
        if (s_fire && part.count != '0)
        begin
            buf_next = part.data;
            cnt_next = part.count;
            end_next = part.text_end;
        end
        else if (m_fire)
        begin
            buf_next = {8'h00, buf_reg[MAX_RESULTS-1:1]};
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            end_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            end_reg <= end_next;
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_RESULTS))
        else $error("output buffer count overflow");

    a_load_count: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire && part.count != '0 |=> m_tvalid && cnt_reg == $past(part.count))
        else $error("output buffer not loaded with the part");

    a_drain_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_fire && m_tlast && !s_fire |=> !m_tvalid)
        else $error("output still valid after last byte left");
`endif

endmodule
